// ----- hdl/assert_macros.svh -----
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every edge out of reset
`define UPC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define UPC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/upc_pkg.sv -----
// ----------------------------------------------------------------------------
// upc_pkg
// Shared types, character constants and classification helpers for the
// url percent codec.
// ----------------------------------------------------------------------------
package upc_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int CFG_ADDR_W  = 1;
  localparam int CFG_DATA_W  = 1;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_DECODE_MODE    = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_PLUS_FOR_SPACE = 1'd1;

  // escape phase codes
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_PCT  = 2'd1;
  localparam logic [1:0] PH_HEX  = 2'd2;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  // one queue entry: up to three result bytes from one input byte
  typedef struct packed {
    logic [2:0][7:0] data;
    logic [1:0]      count;
    logic            last;
  } entry_t;

  function automatic logic is_unreserved(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) ||
           (b >= 8'h30 && b <= 8'h39) || b == 8'h2D || b == 8'h2E ||
           b == 8'h3D || b == 8'h5F || b == 8'h7E;
  endfunction

  function automatic logic is_hex(input logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
           (b >= 8'h61 && b <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_value(input logic [7:0] b);
    logic [3:0] v;
    v = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) v = b[3:0];
    else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66))
      v = b[3:0] + 4'd9;
    return v;
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    logic [7:0] c;
    if (n < 4'd10) c = 8'h30 + {4'd0, n};
    else c = 8'h37 + {4'd0, n};
    return c;
  endfunction

  // append one byte to an entry, dropping anything past three
  function automatic entry_t push_byte(input entry_t e, input logic [7:0] b);
    entry_t r;
    r = e;
    case (e.count)
      2'd0: begin
        r.data[0] = b;
        r.count = 2'd1;
      end
      2'd1: begin
        r.data[1] = b;
        r.count = 2'd2;
      end
      2'd2: begin
        r.data[2] = b;
        r.count = 2'd3;
      end
      default: r = e;
    endcase
    return r;
  endfunction

endpackage

// ----- hdl/url_percent_codec_unit.sv -----
// ----------------------------------------------------------------------------
// url_percent_codec_unit
// Byte-stream url percent encoder / decoder with a direction register.
// ----------------------------------------------------------------------------
// input channel: raise in_push with in_byte/in_last, a transaction completes
//   when in_push is high and in_full is low. in_last closes a string.
// result channel: while out_empty is low the oldest result sits on out_byte,
//   out_run_end and out_string_end; out_pop takes it.
// config: cfg_we writes cfg_wdata to register cfg_addr (0 decode_mode,
//   1 plus_for_space) in the same edge; write only while the block is idle.
// queue: the results of a byte enter the queue at its transaction and can be popped from the next cycle.
// throughput: one input byte per cycle while the entry queue has room; the
//   result side moves one byte per cycle while out_pop is high, through the
//   single-byte result port, so a byte that expands to three results takes three pops.
// a byte that only opens an escape yields no result.
// stall: when out_pop stays low, entries collect in the QUEUE_DEPTH queue and
//   in_full rises once it is full.
// reset: rst_n low clears the queue, the escape state and both registers;
//   the block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module url_percent_codec_unit #(
  parameter int QUEUE_DEPTH = upc_pkg::QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [upc_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [upc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic [7:0]                     in_byte,
  input  logic                           in_last,
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic [7:0]                     out_byte,
  output logic                           out_run_end,
  output logic                           out_string_end
);

  logic decode_mode_r, plus_for_space_r;
  logic queue_full, queue_empty, enq_valid, deq;
  upc_pkg::entry_t enq_entry, head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decode_mode_r    <= 1'b0;
      plus_for_space_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        upc_pkg::REG_DECODE_MODE:    decode_mode_r    <= cfg_wdata[0];
        upc_pkg::REG_PLUS_FOR_SPACE: plus_for_space_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  upc_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .decode_mode    (decode_mode_r),
    .plus_for_space (plus_for_space_r),
    .in_push        (in_push),
    .in_byte        (in_byte),
    .in_last        (in_last),
    .queue_full     (queue_full),
    .in_full        (in_full),
    .enq_valid      (enq_valid),
    .enq_entry      (enq_entry)
  );

  upc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .enq_valid (enq_valid),
    .enq_entry (enq_entry),
    .full      (queue_full),
    .deq       (deq),
    .empty     (queue_empty),
    .head      (head)
  );

  upc_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .queue_empty    (queue_empty),
    .head           (head),
    .deq            (deq),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_byte       (out_byte),
    .out_run_end    (out_run_end),
    .out_string_end (out_string_end)
  );

  // an encoded byte always produces at least one result
  `UPC_ASSERT(a_encode_yields, in_push && !in_full && !decode_mode_r |=> !out_empty, "encode transaction left no result")
  // a full queue always has something to hand out
  `UPC_ASSERT_ALWAYS(a_full_not_empty, in_full |-> !out_empty, "queue full yet result side empty")
  // taking a byte in the middle of a run keeps the rest of that run
  `UPC_ASSERT(a_run_continues, out_pop && !out_empty && !out_run_end |=> !out_empty, "run cut short")

endmodule

// ----- hdl/upc_front.sv -----
// ----------------------------------------------------------------------------
// upc_front
// Accepts input bytes, tracks the escape state and turns each byte that
// yields a result into a queue entry of up to three result bytes.
// ----------------------------------------------------------------------------
module upc_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            decode_mode,
  input  logic            plus_for_space,
  input  logic            in_push,
  input  logic [7:0]      in_byte,
  input  logic            in_last,
  input  logic            queue_full,
  output logic            in_full,
  output logic            enq_valid,
  output upc_pkg::entry_t enq_entry
);

  logic [1:0] phase_r, phase_nxt;
  logic [7:0] held_r, held_nxt;
  logic       accept;
  logic       idle_byte;
  upc_pkg::entry_t ent;

  assign in_full = queue_full;
  assign accept  = in_push && !queue_full;

  always_comb begin
    ent       = '0;
    phase_nxt = phase_r;
    held_nxt  = held_r;
    idle_byte = 1'b0;
    if (!decode_mode) begin
      phase_nxt = upc_pkg::PH_IDLE;
      held_nxt  = 8'd0;
      if (upc_pkg::is_unreserved(in_byte)) begin
        ent = upc_pkg::push_byte(ent, in_byte);
      end else if (in_byte == upc_pkg::CH_SPACE && plus_for_space) begin
        ent = upc_pkg::push_byte(ent, upc_pkg::CH_PLUS);
      end else begin
        ent = upc_pkg::push_byte(ent, upc_pkg::CH_PERCENT);
        ent = upc_pkg::push_byte(ent, upc_pkg::hex_digit(in_byte[7:4]));
        ent = upc_pkg::push_byte(ent, upc_pkg::hex_digit(in_byte[3:0]));
      end
    end else begin
      case (phase_r)
        upc_pkg::PH_PCT: begin
          if (upc_pkg::is_hex(in_byte)) begin
            held_nxt  = in_byte;
            phase_nxt = upc_pkg::PH_HEX;
          end else begin
            ent       = upc_pkg::push_byte(ent, upc_pkg::CH_PERCENT);
            phase_nxt = upc_pkg::PH_IDLE;
            idle_byte = 1'b1;
          end
        end
        upc_pkg::PH_HEX: begin
          if (upc_pkg::is_hex(in_byte)) begin
            ent = upc_pkg::push_byte(ent, {upc_pkg::hex_value(held_r),
                                           upc_pkg::hex_value(in_byte)});
          end else begin
            ent       = upc_pkg::push_byte(ent, upc_pkg::CH_PERCENT);
            ent       = upc_pkg::push_byte(ent, held_r);
            idle_byte = 1'b1;
          end
          phase_nxt = upc_pkg::PH_IDLE;
          held_nxt  = 8'd0;
        end
        default: idle_byte = 1'b1;
      endcase
      if (idle_byte) begin
        if (in_byte == upc_pkg::CH_PLUS && plus_for_space) begin
          ent = upc_pkg::push_byte(ent, upc_pkg::CH_SPACE);
        end else if (in_byte == upc_pkg::CH_PERCENT) begin
          phase_nxt = upc_pkg::PH_PCT;
        end else begin
          ent = upc_pkg::push_byte(ent, in_byte);
        end
      end
      // flush a dangling escape at the string end
      if (in_last) begin
        if (phase_nxt == upc_pkg::PH_PCT) begin
          ent = upc_pkg::push_byte(ent, upc_pkg::CH_PERCENT);
        end else if (phase_nxt == upc_pkg::PH_HEX) begin
          ent = upc_pkg::push_byte(ent, upc_pkg::CH_PERCENT);
          ent = upc_pkg::push_byte(ent, held_nxt);
        end
        phase_nxt = upc_pkg::PH_IDLE;
        held_nxt  = 8'd0;
      end
    end
    ent.last = in_last;
  end

  // bytes that only open an escape produce no entry
  assign enq_valid = accept && (ent.count != 2'd0);
  assign enq_entry = ent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= upc_pkg::PH_IDLE;
      held_r  <= 8'd0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
    end
  end

endmodule

// ----- hdl/upc_queue.sv -----
// ----------------------------------------------------------------------------
// upc_queue
// Small entry queue between the classifier and the serializer.
// ----------------------------------------------------------------------------
module upc_queue #(
  parameter int DEPTH = upc_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            enq_valid,
  input  upc_pkg::entry_t enq_entry,
  output logic            full,
  input  logic            deq,
  output logic            empty,
  output upc_pkg::entry_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  upc_pkg::entry_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_enq, do_deq;

  assign full   = (count_r == CW'(DEPTH));
  assign empty  = (count_r == '0);
  assign head   = mem_r[rd_ptr_r];
  assign do_enq = enq_valid && !full;
  assign do_deq = deq && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_enq) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_deq) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_enq && !do_deq) count_nxt = count_r + 1'b1;
    else if (do_deq && !do_enq) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_enq) mem_r[wr_ptr_r] <= enq_entry;
  end

endmodule

// ----- hdl/upc_back.sv -----
// ----------------------------------------------------------------------------
// upc_back
// Serializes queue entries into single result bytes with run and string
// end marks.
// ----------------------------------------------------------------------------
module upc_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            queue_empty,
  input  upc_pkg::entry_t head,
  output logic            deq,
  output logic            out_empty,
  input  logic            out_pop,
  output logic [7:0]      out_byte,
  output logic            out_run_end,
  output logic            out_string_end
);

  logic [1:0] idx_r, idx_nxt;
  logic       take;

  assign out_empty = queue_empty;
  assign take      = out_pop && !queue_empty;

  always_comb begin
    case (idx_r)
      2'd1:    out_byte = head.data[1];
      2'd2:    out_byte = head.data[2];
      default: out_byte = head.data[0];
    endcase
  end

  assign out_run_end    = (idx_r == head.count - 2'd1);
  assign out_string_end = out_run_end && head.last;
  // the entry leaves once its final byte is taken
  assign deq            = take && out_run_end;

  always_comb begin
    idx_nxt = idx_r;
    if (take) idx_nxt = out_run_end ? 2'd0 : idx_r + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule

// ----- tb/url_percent_codec_checker.sv -----
// ----------------------------------------------------------------------------
// url_percent_codec_checker
// Watches the config port and both queue-style channels of the url percent
// codec, predicts the result bytes of every accepted input byte and compares
// each popped result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module url_percent_codec_checker
  import upc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_push,
  input  logic                  in_full,
  input  logic [7:0]            in_byte,
  input  logic                  in_last,
  input  logic                  out_empty,
  input  logic                  out_pop,
  input  logic [7:0]            out_byte,
  input  logic                  out_run_end,
  input  logic                  out_string_end,
  output int                    fail_count,
  output int                    pending,
  output int                    bytes_in,
  output int                    bytes_out
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] data;
    logic       run_end;
    logic       string_end;
  } codec_result_t;

  localparam logic [8*16-1:0] HEX_CHARS = "0123456789ABCDEF";

  logic       dir_decode = 1'b0;
  logic       plus_space = 1'b0;
  logic [1:0] esc_state  = PH_IDLE;
  logic [7:0] esc_digit  = '0;

  codec_result_t expected_q[$];
  logic [7:0]    step_bytes[$];
  int            errors  = 0;
  int            n_in    = 0;
  int            n_out   = 0;

  function automatic logic is_plain_char(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
           (c >= "0" && c <= "9") || c == "-" || c == "." || c == "=" ||
           c == "_" || c == "~";
  endfunction

  function automatic logic is_hex_char(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") ||
           (c >= "a" && c <= "f");
  endfunction

  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    logic [7:0] v;
    if (c >= "0" && c <= "9") v = c - "0";
    else if (c >= "A" && c <= "F") v = c - "A" + 8'd10;
    else v = c - "a" + 8'd10;
    return v[3:0];
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return HEX_CHARS[8*(15 - n) +: 8];
  endfunction

  // a step never produces more than three bytes, extras are dropped
  task automatic emit_byte(input logic [7:0] c);
    if (step_bytes.size() < 3) step_bytes.push_back(c);
  endtask

  task automatic decode_plain(input logic [7:0] c);
    if (c == CH_PLUS && plus_space) emit_byte(CH_SPACE);
    else if (c == CH_PERCENT) esc_state = PH_PCT;
    else emit_byte(c);
  endtask

  task automatic predict_bytes(input logic [7:0] b, input logic last);
    codec_result_t r;
    step_bytes.delete();
    if (!dir_decode) begin
      // encoding always drops an escape left over from decode mode
      esc_state = PH_IDLE;
      esc_digit = '0;
      if (is_plain_char(b)) begin
        emit_byte(b);
      end else if (b == CH_SPACE && plus_space) begin
        emit_byte(CH_PLUS);
      end else begin
        emit_byte(CH_PERCENT);
        emit_byte(hex_char(b[7:4]));
        emit_byte(hex_char(b[3:0]));
      end
    end else begin
      case (esc_state)
        PH_IDLE: begin
          decode_plain(b);
        end
        PH_PCT: begin
          if (is_hex_char(b)) begin
            esc_digit = b;
            esc_state = PH_HEX;
          end else begin
            emit_byte(CH_PERCENT);
            esc_state = PH_IDLE;
            decode_plain(b);
          end
        end
        default: begin
          if (is_hex_char(b)) begin
            emit_byte({nibble_of(esc_digit), nibble_of(b)});
            esc_state = PH_IDLE;
            esc_digit = '0;
          end else begin
            emit_byte(CH_PERCENT);
            emit_byte(esc_digit);
            esc_state = PH_IDLE;
            esc_digit = '0;
            decode_plain(b);
          end
        end
      endcase
      // flush a dangling escape at the string end
      if (last) begin
        if (esc_state == PH_PCT) begin
          emit_byte(CH_PERCENT);
        end else if (esc_state == PH_HEX) begin
          emit_byte(CH_PERCENT);
          emit_byte(esc_digit);
        end
        esc_state = PH_IDLE;
        esc_digit = '0;
      end
    end
    foreach (step_bytes[i]) begin
      r.data       = step_bytes[i];
      r.run_end    = (i == step_bytes.size() - 1);
      r.string_end = r.run_end && last;
      expected_q.push_back(r);
    end
  endtask

  task automatic check_result();
    codec_result_t want;
    n_out++;
    if (expected_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected result transaction, byte %h", $time, out_byte);
    end else begin
      want = expected_q.pop_front();
      if (out_byte !== want.data) begin
        errors++;
        $display("%0t: out_byte expected %h actual %h", $time, want.data, out_byte);
      end
      if (out_run_end !== want.run_end) begin
        errors++;
        $display("%0t: out_run_end expected %b actual %b", $time, want.run_end,
                 out_run_end);
      end
      if (out_string_end !== want.string_end) begin
        errors++;
        $display("%0t: out_string_end expected %b actual %b", $time,
                 want.string_end, out_string_end);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      dir_decode = 1'b0;
      plus_space = 1'b0;
      esc_state  = PH_IDLE;
      esc_digit  = '0;
      expected_q.delete();
    end else begin
      if (out_pop && !out_empty) check_result();
      if (cfg_we) begin
        if (cfg_addr == REG_DECODE_MODE) dir_decode = cfg_wdata[0];
        else if (cfg_addr == REG_PLUS_FOR_SPACE) plus_space = cfg_wdata[0];
      end
      if (in_push && !in_full) begin
        n_in++;
        predict_bytes(in_byte, in_last);
      end
    end
    pending    <= expected_q.size();
    fail_count <= errors;
    bytes_in   <= n_in;
    bytes_out  <= n_out;
  end

endmodule

// ----- tb/url_percent_codec_unit_tb.sv -----
// ----------------------------------------------------------------------------
// url_percent_codec_unit_tb
// Drives byte strings through the url percent codec in every mode setting,
// with random idle cycles on both channels, and reports the verdict from the
// checker's failure count.
// ----------------------------------------------------------------------------
module url_percent_codec_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import upc_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_push;
  logic                  in_full;
  logic [7:0]            in_byte;
  logic                  in_last;
  logic                  out_empty;
  logic                  out_pop;
  logic [7:0]            out_byte;
  logic                  out_run_end;
  logic                  out_string_end;

  int fail_count;
  int pending;
  int bytes_in;
  int bytes_out;
  int send_idle_pct = 16;
  int pop_idle_pct;
  int items_sent    = 0;

  url_percent_codec_unit u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_byte        (in_byte),
    .in_last        (in_last),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_byte       (out_byte),
    .out_run_end    (out_run_end),
    .out_string_end (out_string_end)
  );

  url_percent_codec_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_byte        (in_byte),
    .in_last        (in_last),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_byte       (out_byte),
    .out_run_end    (out_run_end),
    .out_string_end (out_string_end),
    .fail_count     (fail_count),
    .pending        (pending),
    .bytes_in       (bytes_in),
    .bytes_out      (bytes_out)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  // result side stalls at random
  always @(posedge clk) begin
    out_pop <= ($urandom_range(99) >= pop_idle_pct);
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_push <= 1'b1;
    in_byte <= b;
    in_last <= last;
    do @(posedge clk); while (in_full);
    items_sent++;
  endtask

  task automatic send_text(input string s, input logic close);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], close && i == s.len() - 1);
  endtask

  // hold off until every predicted result has been popped
  task automatic wait_drained();
    in_push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic set_mode(input logic decode, input logic plus);
    wait_drained();
    write_reg(REG_DECODE_MODE, decode);
    write_reg(REG_PLUS_FOR_SPACE, plus);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] pick_hex();
    int n;
    logic [7:0] c;
    n = $urandom_range(15);
    if (n < 10) c = 8'("0" + n);
    else if ($urandom_range(1)) c = 8'("A" + n - 10);
    else c = 8'("a" + n - 10);
    return c;
  endfunction

  // decode strings draw half their items as well-formed escapes, some as broken ones
  task automatic send_random_string(input logic decode);
    logic [7:0] s[$];
    int len;
    int kind;
    len = $urandom_range(1, 6);
    repeat (len) begin
      kind = $urandom_range(99);
      if (!decode) begin
        if (kind < 15) s.push_back(CH_SPACE);
        else if (kind < 20) s.push_back(CH_PLUS);
        else if (kind < 40) s.push_back(8'("a" + $urandom_range(25)));
        else s.push_back(8'($urandom_range(255)));
      end else if (kind < 50) begin
        s.push_back(CH_PERCENT);
        s.push_back(pick_hex());
        s.push_back(pick_hex());
      end else if (kind < 58) begin
        s.push_back(CH_PERCENT);
        s.push_back(pick_hex());
      end else if (kind < 63) begin
        s.push_back(CH_PERCENT);
      end else if (kind < 73) begin
        s.push_back(CH_PLUS);
      end else if (kind < 78) begin
        s.push_back(CH_SPACE);
      end else if (kind < 88) begin
        s.push_back(8'($urandom_range(32, 126)));
      end else begin
        s.push_back(8'($urandom_range(255)));
      end
    end
    foreach (s[i]) send_byte(s[i], i == s.size() - 1);
  endtask

  initial begin
    int target;
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_addr     <= '0;
    cfg_wdata    <= '0;
    in_push      <= 1'b0;
    in_byte      <= '0;
    in_last      <= 1'b0;
    pop_idle_pct <= 68;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // encode: byte extremes, unreserved, space without plus, percent
    set_mode(1'b0, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_text("Az~ %", 1'b1);
    set_mode(1'b0, 1'b1);
    send_text(" +", 1'b1);

    // decode: plus, good escape, malformed after digit and after percent,
    // high byte in place of a digit, flush of a held digit at the string end
    set_mode(1'b1, 1'b1);
    send_text("+%41%4G%z", 1'b0);
    send_byte(CH_PERCENT, 1'b0);
    send_byte(8'hC6, 1'b0);
    send_text("%a", 1'b1);
    // broken escape plus a new percent at the end fills all three result bytes
    send_text("%4%", 1'b1);
    // escape left open, then dropped by an encode step
    send_text("%4", 1'b0);
    set_mode(1'b0, 1'b1);
    send_text("x", 1'b1);

    for (int ph = 0; ph < 3; ph++) begin
      wait_drained();
      case (ph)
        0: begin
          send_idle_pct = 16;
          pop_idle_pct <= 68;
        end
        1: begin
          send_idle_pct = 68;
          pop_idle_pct <= 16;
        end
        default: begin
          send_idle_pct = 0;
          pop_idle_pct <= 0;
        end
      endcase
      for (int m = 0; m < 4; m++) begin
        set_mode(m[1], m[0]);
        target = items_sent + 6;
        while (items_sent < target) send_random_string(m[1]);
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    $display("covered %0d input bytes and %0d result bytes", bytes_in, bytes_out);
    $display("all four mode settings under three idle profiles, bad escapes and flushes");
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
